// File: design/vn3_pkg.sv
// Shared types, constants and the blend function of the 3D value noise block.
package vn3_pkg;

	localparam int TABLE_BITS = 8;
	localparam int FRAC_BITS = 16;
	localparam int VALUE_BITS = 16;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	localparam logic [1:0] SEL_VALUE = 2'd0;
	localparam logic [1:0] SEL_PERM_X = 2'd1;
	localparam logic [1:0] SEL_PERM_Y = 2'd2;
	localparam logic [1:0] SEL_PERM_Z = 2'd3;

	typedef logic [TABLE_BITS-1:0] cell_t;
	typedef logic [FRAC_BITS-1:0] frac_t;
	typedef logic [VALUE_BITS-1:0] value_t;

	// Linear blend (a*(1-s) + b*s) in Q0.F, saturated to the value range.
	function automatic value_t lerp(input value_t a, input value_t b, input frac_t s);
		logic [FRAC_BITS:0] w;
		logic [VALUE_BITS+FRAC_BITS+1:0] sum;
		w = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(s);
		sum = (VALUE_BITS+FRAC_BITS+2)'(a) * (VALUE_BITS+FRAC_BITS+2)'(w)
			+ (VALUE_BITS+FRAC_BITS+2)'(b) * (VALUE_BITS+FRAC_BITS+2)'(s);
		if (sum[VALUE_BITS+FRAC_BITS+1:VALUE_BITS+FRAC_BITS] != 2'b00) begin
			return '1;
		end
		return sum[VALUE_BITS+FRAC_BITS-1:FRAC_BITS];
	endfunction

endpackage

// File: design/vn3_ram.sv
// Table memory with one write port and two registered read ports.
module vn3_ram #(
	parameter int W = 8
) (
	input  logic               clk,
	input  logic               en,
	input  logic               we,
	input  vn3_pkg::cell_t     waddr,
	input  logic [W-1:0]       wdata,
	input  vn3_pkg::cell_t     raddr_a,
	input  vn3_pkg::cell_t     raddr_b,
	output logic [W-1:0]       rdata_a,
	output logic [W-1:0]       rdata_b
);
	import vn3_pkg::*;

	logic [W-1:0] mem [1 << TABLE_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Reads hold while the pipeline is frozen.
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

// File: design/vn3_smooth.sv
// Two-stage Hermite smoothing s = t*t*(3-2t) of one fraction.
module vn3_smooth (
	input  logic           clk,
	input  logic           en,
	input  vn3_pkg::frac_t t,
	output vn3_pkg::frac_t s
);
	import vn3_pkg::*;

	logic [2*FRAC_BITS-1:0] sq;
	frac_t q_s2;
	frac_t t_s2;
	logic [FRAC_BITS+1:0] k;
	logic [2*FRAC_BITS+1:0] prod;

	assign sq = (2*FRAC_BITS)'(t) * (2*FRAC_BITS)'(t);
	assign k = (FRAC_BITS+2)'(3 << FRAC_BITS) - {1'b0, t_s2, 1'b0};
	assign prod = (2*FRAC_BITS+2)'(q_s2) * (2*FRAC_BITS+2)'(k);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2 <= sq[2*FRAC_BITS-1:FRAC_BITS];
			t_s2 <= t;
			s <= prod[2*FRAC_BITS-1:FRAC_BITS];
		end
	end
endmodule

// File: design/value_noise_3d_trilinear.sv
// Top level of the 3D lattice value noise pipeline with trilinear blending.
//
// Items arrive on the item channel (item_valid / item_stall). A beat with
// kind at zero writes one entry of the value table or of one of the three
// permutation tables and produces no result. A beat with kind at one
// evaluates the noise at the Q16.16 point (coord_x, coord_y, coord_z) and
// produces one noise_value beat on the noise channel from stage s6.
// One beat of either kind is taken in every cycle while item_stall is low;
// the tables are read at two addresses per cycle, and the value table is held
// in four copies so that all eight corners are looked up in the same cycle.
// Reset clears only the valid bits of the pipeline. The tables are not
// cleared, so every entry must be written before a point reads it.
// When the receiver stalls a waiting result, the whole pipeline freezes
// and item_stall rises in the same cycle; nothing is lost or repeated.
// Stages: s1 permutation reads and fractions, s2 corner values and t*t,
// s3 smoothed fractions, s4 blend along z, s5 along y, s6 along x.
module value_noise_3d_trilinear (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  kind,
	input  logic [1:0]            table_select,
	input  logic [7:0]            table_index,
	input  logic [15:0]           table_value,
	input  logic signed [31:0]    coord_x,
	input  logic signed [31:0]    coord_y,
	input  logic signed [31:0]    coord_z,
	output logic                  noise_valid,
	input  logic                  noise_stall,
	output logic [15:0]           noise_value
);
	import vn3_pkg::*;

	logic adv;
	logic accept;
	logic wr;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	cell_t cx0, cx1, cy0, cy1, cz0, cz1;
	cell_t px0_s1, px1_s1, py0_s1, py1_s1, pz0_s1, pz1_s1;
	frac_t fx_s1, fy_s1, fz_s1;
	cell_t hash [8];
	value_t val_s2 [8];
	value_t val_s3 [8];
	frac_t su_s3, sv_s3, sw_s3;
	frac_t su_s4, sv_s4, su_s5;
	value_t z_s4 [4];
	value_t y_s5 [2];
	value_t noise_s6;

	// The pipeline moves as one unit unless a finished result is held.
	assign adv = !valid_s6 || !noise_stall;
	assign item_stall = !adv;
	assign accept = item_valid && adv;
	assign wr = accept && (kind == KIND_WRITE);

	// The cell index modulo the table size is just the low integer bits.
	assign cx0 = coord_x[FRAC_BITS+TABLE_BITS-1:FRAC_BITS];
	assign cy0 = coord_y[FRAC_BITS+TABLE_BITS-1:FRAC_BITS];
	assign cz0 = coord_z[FRAC_BITS+TABLE_BITS-1:FRAC_BITS];
	assign cx1 = cx0 + 1'b1;
	assign cy1 = cy0 + 1'b1;
	assign cz1 = cz0 + 1'b1;

	vn3_ram #(.W(TABLE_BITS)) u_perm_x (
		.clk, .en(adv), .we(wr && (table_select == SEL_PERM_X)),
		.waddr(table_index), .wdata(table_value[TABLE_BITS-1:0]),
		.raddr_a(cx0), .raddr_b(cx1), .rdata_a(px0_s1), .rdata_b(px1_s1)
	);
	vn3_ram #(.W(TABLE_BITS)) u_perm_y (
		.clk, .en(adv), .we(wr && (table_select == SEL_PERM_Y)),
		.waddr(table_index), .wdata(table_value[TABLE_BITS-1:0]),
		.raddr_a(cy0), .raddr_b(cy1), .rdata_a(py0_s1), .rdata_b(py1_s1)
	);
	vn3_ram #(.W(TABLE_BITS)) u_perm_z (
		.clk, .en(adv), .we(wr && (table_select == SEL_PERM_Z)),
		.waddr(table_index), .wdata(table_value[TABLE_BITS-1:0]),
		.raddr_a(cz0), .raddr_b(cz1), .rdata_a(pz0_s1), .rdata_b(pz1_s1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s1 <= coord_x[FRAC_BITS-1:0];
			fy_s1 <= coord_y[FRAC_BITS-1:0];
			fz_s1 <= coord_z[FRAC_BITS-1:0];
		end
	end

	// Corner c has x offset c[2], y offset c[1] and z offset c[0].
	always_comb begin
		for (int c = 0; c < 8; c++) begin
			hash[c] = (c[2] ? px1_s1 : px0_s1) ^ (c[1] ? py1_s1 : py0_s1)
				^ (c[0] ? pz1_s1 : pz0_s1);
		end
	end

	// Each copy of the value table serves the two z corners of one column.
	for (genvar m = 0; m < 4; m++) begin : g_val
		vn3_ram #(.W(VALUE_BITS)) u_val (
			.clk, .en(adv), .we(wr && (table_select == SEL_VALUE)),
			.waddr(table_index), .wdata(table_value[VALUE_BITS-1:0]),
			.raddr_a(hash[2*m]), .raddr_b(hash[2*m+1]),
			.rdata_a(val_s2[2*m]), .rdata_b(val_s2[2*m+1])
		);
	end

	vn3_smooth u_sm_x (.clk, .en(adv), .t(fx_s1), .s(su_s3));
	vn3_smooth u_sm_y (.clk, .en(adv), .t(fy_s1), .s(sv_s3));
	vn3_smooth u_sm_z (.clk, .en(adv), .t(fz_s1), .s(sw_s3));

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s3 <= val_s2;
			for (int m = 0; m < 4; m++) begin
				z_s4[m] <= lerp(val_s3[2*m], val_s3[2*m+1], sw_s3);
			end
			su_s4 <= su_s3;
			sv_s4 <= sv_s3;
			y_s5[0] <= lerp(z_s4[0], z_s4[1], sv_s4);
			y_s5[1] <= lerp(z_s4[2], z_s4[3], sv_s4);
			su_s5 <= su_s4;
			noise_s6 <= lerp(y_s5[0], y_s5[1], su_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && (kind == KIND_EVAL);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign noise_valid = valid_s6;
	assign noise_value = noise_s6;

	// An accepted point enters the first stage; a table write never does.
	a_eval_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && kind == KIND_EVAL) |=> valid_s1)
		else $error("accepted point did not enter the pipeline");
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && kind == KIND_WRITE) |=> !valid_s1)
		else $error("table write entered the result pipeline");
	// A held result freezes the stages behind it.
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(noise_valid && noise_stall) |=> ($stable(valid_s5) && $stable(valid_s1)))
		else $error("pipeline moved while the result was stalled");
endmodule
